>>> rtl/windowed_peak_differential_meter_core_macros.svh
// assertion helpers shared by the meter rtl
`ifndef WINDOWED_PEAK_DIFFERENTIAL_METER_CORE_MACROS_SVH
`define WINDOWED_PEAK_DIFFERENTIAL_METER_CORE_MACROS_SVH

// property that must hold on every clock edge out of reset
`define WPDM_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// property whose consequent must hold in the cycle after the antecedent
`define WPDM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/wpdm_pkg.sv
`default_nettype none

package wpdm_pkg;

    // field widths
    localparam int ADC_BITS    = 12;
    localparam int RAW_W       = 12;
    localparam int SCALE_W     = 16;
    localparam int AMP_W       = 12;
    localparam int MILLI_W     = 10;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    // sizing and arithmetic constants
    localparam int WINDOW_DEFAULT = 200;
    localparam int ADC_FULL       = (1 << ADC_BITS) - 1;
    localparam int PROD_W         = ADC_BITS + SCALE_W;
    localparam int MILLI_PROD_W   = ADC_BITS + MILLI_W;
    localparam logic [SCALE_W-1:0] MILLI_SCALE      = SCALE_W'(1000);
    localparam logic [SCALE_W-1:0] LOW_SCALE_RESET  = SCALE_W'(12234);
    localparam logic [SCALE_W-1:0] HIGH_SCALE_RESET = SCALE_W'(45754);

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_SCALE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_SCALE = 1'b1;

    // opcodes
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef logic [ADC_BITS-1:0] sample_t;

    typedef struct packed {
        sample_t low_line;
        sample_t low_neutral;
        sample_t high_line;
        sample_t high_neutral;
    } sample_set_t;

    typedef struct packed {
        sample_t             a;
        logic [SCALE_W-1:0]  b;
    } mul_op_t;

    typedef struct packed {
        logic [AMP_W-1:0]   low_amplitude;
        logic [MILLI_W-1:0] low_line_milli;
        logic [MILLI_W-1:0] low_neutral_milli;
        logic [AMP_W-1:0]   high_amplitude;
        logic [MILLI_W-1:0] high_line_milli;
        logic [MILLI_W-1:0] high_neutral_milli;
    } report_t;

    function automatic sample_t abs_diff(sample_t x, sample_t y);
        return (x >= y) ? (x - y) : (y - x);
    endfunction

endpackage

`default_nettype wire

>>> rtl/wpdm_in_if.sv
`default_nettype none

interface wpdm_in_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [wpdm_pkg::RAW_W-1:0]    low_line_raw;
    logic [wpdm_pkg::RAW_W-1:0]    low_neutral_raw;
    logic [wpdm_pkg::RAW_W-1:0]    high_line_raw;
    logic [wpdm_pkg::RAW_W-1:0]    high_neutral_raw;

    modport source (
        output valid, opcode, low_line_raw, low_neutral_raw, high_line_raw, high_neutral_raw,
        input  ready
    );

    modport sink (
        input  valid, opcode, low_line_raw, low_neutral_raw, high_line_raw, high_neutral_raw,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/wpdm_out_if.sv
`default_nettype none

interface wpdm_out_if;
    logic                            valid;
    logic                            ready;
    logic [wpdm_pkg::AMP_W-1:0]      low_amplitude;
    logic [wpdm_pkg::MILLI_W-1:0]    low_line_milli;
    logic [wpdm_pkg::MILLI_W-1:0]    low_neutral_milli;
    logic [wpdm_pkg::AMP_W-1:0]      high_amplitude;
    logic [wpdm_pkg::MILLI_W-1:0]    high_line_milli;
    logic [wpdm_pkg::MILLI_W-1:0]    high_neutral_milli;

    modport source (
        output valid, low_amplitude, low_line_milli, low_neutral_milli,
               high_amplitude, high_line_milli, high_neutral_milli,
        input  ready
    );

    modport sink (
        input  valid, low_amplitude, low_line_milli, low_neutral_milli,
               high_amplitude, high_line_milli, high_neutral_milli,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/wpdm_ram.sv
`default_nettype none

module wpdm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 200
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/wpdm_peak_unit.sv
`default_nettype none

module wpdm_peak_unit (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   clear,
    input  wire logic                   sample_valid,
    input  wire wpdm_pkg::sample_set_t  sample,
    output wpdm_pkg::sample_set_t       held
);

    wpdm_pkg::sample_t     best_low_reg;
    wpdm_pkg::sample_t     best_high_reg;
    wpdm_pkg::sample_set_t held_reg;
    wpdm_pkg::sample_t     d_low;
    wpdm_pkg::sample_t     d_high;
    logic                  win_low;
    logic                  win_high;

    // difference of each pair for the entry coming out of the ring
    assign d_low    = wpdm_pkg::abs_diff(sample.low_line, sample.low_neutral);
    assign d_high   = wpdm_pkg::abs_diff(sample.high_line, sample.high_neutral);
    assign win_low  = sample_valid && (d_low > best_low_reg);
    assign win_high = sample_valid && (d_high > best_high_reg);

    // running maximum, first strict winner keeps its samples
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_low_reg  <= '0;
            best_high_reg <= '0;
            held_reg      <= '0;
        end
        else if (clear)
        begin
            best_low_reg  <= '0;
            best_high_reg <= '0;
        end
        else
        begin
            if (win_low)
            begin
                best_low_reg         <= d_low;
                held_reg.low_line    <= sample.low_line;
                held_reg.low_neutral <= sample.low_neutral;
            end
            if (win_high)
            begin
                best_high_reg         <= d_high;
                held_reg.high_line    <= sample.high_line;
                held_reg.high_neutral <= sample.high_neutral;
            end
        end
    end

    assign held = held_reg;

endmodule

`default_nettype wire

>>> rtl/wpdm_mul_unit.sv
`default_nettype none

module wpdm_mul_unit (
    input  wire logic                          clk,
    input  wire wpdm_pkg::mul_op_t             op,
    output logic [wpdm_pkg::AMP_W-1:0]         amp,
    output logic [wpdm_pkg::MILLI_W-1:0]       milli
);

    logic [wpdm_pkg::PROD_W-1:0]       prod_reg;
    logic [wpdm_pkg::MILLI_PROD_W-1:0] x;
    logic [wpdm_pkg::MILLI_W-1:0]      q0;
    logic [wpdm_pkg::ADC_BITS:0]       rem;
    logic                              fix;

    // shared multiplier, product registered every cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= wpdm_pkg::PROD_W'(op.a) * wpdm_pkg::PROD_W'(op.b);
    end

    // amplitude is the q16 product shifted down
    assign amp = prod_reg[wpdm_pkg::SCALE_W +: wpdm_pkg::AMP_W];

    // divide by full scale: x = q0*full + (low bits + q0), one correction step
    assign x     = prod_reg[wpdm_pkg::MILLI_PROD_W-1:0];
    assign q0    = x[wpdm_pkg::MILLI_PROD_W-1 -: wpdm_pkg::MILLI_W];
    assign rem   = {1'b0, x[wpdm_pkg::ADC_BITS-1:0]} + (wpdm_pkg::ADC_BITS+1)'(q0);
    assign fix   = (rem >= (wpdm_pkg::ADC_BITS+1)'(wpdm_pkg::ADC_FULL));
    assign milli = q0 + wpdm_pkg::MILLI_W'(fix);

endmodule

`default_nettype wire

>>> rtl/windowed_peak_differential_meter_core.sv
// store item: one store item per cycle back to back while no read item is in progress
// read item: no new item is accepted until its report is loaded into the output register;
//   one ring entry read per cycle, then six products on one multiplier
// a read item holds in its last state while the output register has an unaccepted report
// reset: scales to defaults, pointer, fill count and held peaks to zero; ring
//   entries not yet written since reset are kept out of the peak search by the fill count
`default_nettype none

`include "windowed_peak_differential_meter_core_macros.svh"

module windowed_peak_differential_meter_core #(
    parameter int WINDOW = wpdm_pkg::WINDOW_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [wpdm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [wpdm_pkg::CFG_DATA_W-1:0]     cfg_data,
    wpdm_in_if.sink                                  cmd,
    wpdm_out_if.source                               report
);

    localparam int ADDR_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_CALC  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // multiplier steps
    localparam logic [2:0] STEP_LOW_AMP      = 3'd0;
    localparam logic [2:0] STEP_LOW_LINE     = 3'd1;
    localparam logic [2:0] STEP_LOW_NEUTRAL  = 3'd2;
    localparam logic [2:0] STEP_HIGH_AMP     = 3'd3;
    localparam logic [2:0] STEP_HIGH_LINE    = 3'd4;
    localparam logic [2:0] STEP_HIGH_NEUTRAL = 3'd5;
    localparam logic [2:0] STEP_END          = 3'd6;

    logic [2:0]                      state_reg, state_next;
    logic [ADDR_W-1:0]               scan_addr_reg, scan_addr_next;
    logic [2:0]                      step_reg, step_next;
    logic [ADDR_W-1:0]               wptr_reg;
    logic [CNT_W-1:0]                fill_reg;
    logic                            rd_pend_reg;
    logic                            rd_live_reg;
    logic [wpdm_pkg::SCALE_W-1:0]    low_scale_reg;
    logic [wpdm_pkg::SCALE_W-1:0]    high_scale_reg;
    wpdm_pkg::report_t               res_reg;
    wpdm_pkg::report_t               out_reg;
    logic                            out_valid_reg;

    logic                            cmd_accept;
    logic                            ram_we;
    logic                            scan_start;
    logic                            out_load;
    logic                            cap_en;
    logic [2:0]                      cap_step;
    wpdm_pkg::sample_set_t           wdata;
    logic [$bits(wpdm_pkg::sample_set_t)-1:0] ram_rdata;
    wpdm_pkg::sample_set_t           held;
    wpdm_pkg::mul_op_t               mul_op;
    logic [wpdm_pkg::AMP_W-1:0]      mul_amp;
    logic [wpdm_pkg::MILLI_W-1:0]    mul_milli;

    // input handshake
    assign cmd.ready  = (state_reg == ST_IDLE);
    assign cmd_accept = cmd.valid && cmd.ready;
    assign ram_we     = cmd_accept && (cmd.opcode == wpdm_pkg::OP_STORE);
    assign scan_start = cmd_accept && (cmd.opcode == wpdm_pkg::OP_READ);

    assign wdata.low_line     = cmd.low_line_raw[wpdm_pkg::ADC_BITS-1:0];
    assign wdata.low_neutral  = cmd.low_neutral_raw[wpdm_pkg::ADC_BITS-1:0];
    assign wdata.high_line    = cmd.high_line_raw[wpdm_pkg::ADC_BITS-1:0];
    assign wdata.high_neutral = cmd.high_neutral_raw[wpdm_pkg::ADC_BITS-1:0];

    // all four rings share one address, so one wide ram
    wpdm_ram #(
        .WIDTH ($bits(wpdm_pkg::sample_set_t)),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata (wdata),
        .raddr (scan_addr_reg),
        .rdata (ram_rdata)
    );

    // peak search over the scanned entries
    wpdm_peak_unit u_peak (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (scan_start),
        .sample_valid (rd_pend_reg && rd_live_reg),
        .sample       (wpdm_pkg::sample_set_t'(ram_rdata)),
        .held         (held)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        case (step_reg)
            STEP_LOW_AMP:
            begin
                mul_op.a = wpdm_pkg::abs_diff(held.low_line, held.low_neutral);
                mul_op.b = low_scale_reg;
            end
            STEP_LOW_LINE:
            begin
                mul_op.a = held.low_line;
                mul_op.b = wpdm_pkg::MILLI_SCALE;
            end
            STEP_LOW_NEUTRAL:
            begin
                mul_op.a = held.low_neutral;
                mul_op.b = wpdm_pkg::MILLI_SCALE;
            end
            STEP_HIGH_AMP:
            begin
                mul_op.a = wpdm_pkg::abs_diff(held.high_line, held.high_neutral);
                mul_op.b = high_scale_reg;
            end
            STEP_HIGH_LINE:
            begin
                mul_op.a = held.high_line;
                mul_op.b = wpdm_pkg::MILLI_SCALE;
            end
            STEP_HIGH_NEUTRAL:
            begin
                mul_op.a = held.high_neutral;
                mul_op.b = wpdm_pkg::MILLI_SCALE;
            end
            default:
            begin
                mul_op.a = '0;
                mul_op.b = '0;
            end
        endcase
    end

    wpdm_mul_unit u_mul (
        .clk   (clk),
        .op    (mul_op),
        .amp   (mul_amp),
        .milli (mul_milli)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        scan_addr_next = scan_addr_reg;
        step_next      = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (scan_start)
                begin
                    state_next     = ST_SCAN;
                    scan_addr_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (scan_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_CALC;
                step_next  = STEP_LOW_AMP;
            end
            ST_CALC:
            begin
                if (step_reg == STEP_END)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_addr_reg <= '0;
            step_reg      <= STEP_LOW_AMP;
            rd_pend_reg   <= 1'b0;
            rd_live_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_addr_reg <= scan_addr_next;
            step_reg      <= step_next;
            rd_pend_reg   <= (state_reg == ST_SCAN);
            rd_live_reg   <= (CNT_W'(scan_addr_reg) < fill_reg);
        end
    end

    // write pointer and count of entries written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            fill_reg <= '0;
        end
        else if (ram_we)
        begin
            wptr_reg <= (wptr_reg == LAST_ADDR) ? '0 : wptr_reg + 1'b1;
            if (fill_reg != FULL_CNT)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    // scale registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_scale_reg  <= wpdm_pkg::LOW_SCALE_RESET;
            high_scale_reg <= wpdm_pkg::HIGH_SCALE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                wpdm_pkg::CFG_LOW_SCALE:  low_scale_reg  <= cfg_data;
                wpdm_pkg::CFG_HIGH_SCALE: high_scale_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // collect each product in the cycle after its operands went in
    assign cap_en   = (state_reg == ST_CALC) && (step_reg != STEP_LOW_AMP);
    assign cap_step = step_reg - 1'b1;

    always_ff @(posedge clk)
    begin
        if (cap_en)
        begin
            case (cap_step)
                STEP_LOW_AMP:      res_reg.low_amplitude      <= mul_amp;
                STEP_LOW_LINE:     res_reg.low_line_milli     <= mul_milli;
                STEP_LOW_NEUTRAL:  res_reg.low_neutral_milli  <= mul_milli;
                STEP_HIGH_AMP:     res_reg.high_amplitude     <= mul_amp;
                STEP_HIGH_LINE:    res_reg.high_line_milli    <= mul_milli;
                STEP_HIGH_NEUTRAL: res_reg.high_neutral_milli <= mul_milli;
                default:           ;
            endcase
        end
    end

    // output register
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || report.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    assign report.valid              = out_valid_reg;
    assign report.low_amplitude      = out_reg.low_amplitude;
    assign report.low_line_milli     = out_reg.low_line_milli;
    assign report.low_neutral_milli  = out_reg.low_neutral_milli;
    assign report.high_amplitude     = out_reg.high_amplitude;
    assign report.high_line_milli    = out_reg.high_line_milli;
    assign report.high_neutral_milli = out_reg.high_neutral_milli;

    // checks
    `WPDM_ASSERT(a_fill_bound, fill_reg <= FULL_CNT, "fill count beyond window")
    `WPDM_ASSERT(a_store_idle, !ram_we || (state_reg == ST_IDLE), "ring written during a read")
    `WPDM_ASSERT_NEXT(a_scan_step, (state_reg == ST_SCAN) && (scan_addr_reg != LAST_ADDR),
                      scan_addr_reg == $past(scan_addr_reg) + 1'b1, "scan address skipped")
    `WPDM_ASSERT_NEXT(a_report_load, out_load, report.valid && (state_reg == ST_IDLE),
                      "report not presented after load")

endmodule

`default_nettype wire
